### src/rrf_pkg.sv
// ----------------------------------------------------------------------------
// Rounded rectangle fill package
// Shared constants and types for the rounded rectangle fill engine.
// ----------------------------------------------------------------------------
package rrf_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;

    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_SMALL   = 2'd1;
    localparam logic [1:0] ST_OUTSIDE = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_SQRT,
        S_PIX_RD,
        S_PIX_WAIT,
        S_PIX_WR,
        S_ACC,
        S_ACC_WAIT,
        S_RESULT
    } state_t;

endpackage

### src/rounded_rect_or_fill_core.sv
// ----------------------------------------------------------------------------
// Rounded rectangle fill core
// A byte framebuffer with a scanning OR fill of rounded rectangles and
// single pixel read and write access.
// ----------------------------------------------------------------------------
// Steps: a pixel read or write passes setup, the access and its read wait,
// then the result; a skipped or fully clipped draw goes from setup straight
// to the result. A draw scans the clipped box pixel by pixel (read, read
// wait, OR write-back), with a bit-serial square root at each corner row.
// Throughput: one item at a time; the next is taken after the result leaves.
// Reset clears all MAX_WIDTH*MAX_HEIGHT frame entries, one entry per cycle.
module rounded_rect_or_fill_core
    import rrf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic signed [15:0] left,
    input  logic signed [15:0] top,
    input  logic signed [15:0] right,
    input  logic signed [15:0] bottom,
    input  logic [7:0]         radius,
    input  logic [7:0]         color,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [7:0]         pixel,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);

    // Frame memory with registered read data.
    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= mem[mem_raddr];
    end

    // Configuration registers.
    logic [7:0] sw_reg;
    logic [7:0] sh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= 8'd128;
            sh_reg <= 8'd128;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_WIDTH)
            begin
                sw_reg <= cfg_data;
            end
            else
            begin
                sh_reg <= cfg_data;
            end
        end
    end

    // Effective screen size: zero acts as one, oversize is capped.
    logic [XW-1:0] eff_w;
    logic [YW-1:0] eff_h;

    always_comb
    begin
        if (sw_reg == 8'd0)
            eff_w = XW'(1);
        else if (32'(sw_reg) > MAX_WIDTH)
            eff_w = XW'(MAX_WIDTH);
        else
            eff_w = XW'(sw_reg);
        if (sh_reg == 8'd0)
            eff_h = YW'(1);
        else if (32'(sh_reg) > MAX_HEIGHT)
            eff_h = YW'(MAX_HEIGHT);
        else
            eff_h = YW'(sh_reg);
    end

    // Item registers.
    state_t               state_reg, state_next;
    logic [1:0]           func_reg;
    logic signed [17:0]   x0_reg, y0_reg, x1_reg, y1_reg;
    logic [7:0]           r_reg;
    logic [7:0]           color_reg;
    logic [1:0]           status_reg;
    logic [7:0]           pixel_reg;
    logic [AW:0]          clr_reg;
    logic signed [17:0]   sx_reg, sy_reg;
    logic signed [17:0]   xs_reg, xe_reg, ye_reg;
    logic [7:0]           span_reg;
    logic [7:0]           root_reg;
    logic [3:0]           bit_reg;
    logic [AW-1:0]        addr_reg;

    // Row offset into the corner region for the current scan row.
    logic signed [17:0] top_in, bot_in, dy;
    logic               in_corner_row;
    logic [7:0]         dy8;
    logic [15:0]        rad_sq;

    always_comb
    begin
        top_in = y0_reg + 18'(r_reg) - sy_reg;
        bot_in = sy_reg - (y1_reg - 18'(r_reg));
        if (top_in > 0)
        begin
            dy = top_in;
            in_corner_row = 1'b1;
        end
        else if (bot_in > 0)
        begin
            dy = bot_in;
            in_corner_row = 1'b1;
        end
        else
        begin
            dy = '0;
            in_corner_row = 1'b0;
        end
        dy8    = dy[7:0];
        rad_sq = r_reg * r_reg - dy8 * dy8;
    end

    // Pixel coverage test against the shape for the current scan position.
    logic        covered;
    logic signed [17:0] lx, rx;

    always_comb
    begin
        lx = x0_reg + 18'(r_reg);
        rx = x1_reg - 18'(r_reg);
        if (!in_corner_row)
            covered = 1'b1;
        else if (sx_reg >= lx && sx_reg <= rx)
            covered = 1'b1;
        else if (sx_reg < lx)
            covered = (lx - sx_reg) <= 18'(span_reg);
        else
            covered = (sx_reg - rx) <= 18'(span_reg);
    end

    // Clipped box of the whole rectangle.
    logic signed [17:0] cxs, cxe, cys, cye;
    logic signed [17:0] ws, hs;
    logic               ys_empty;

    always_comb
    begin
        ws  = 18'(eff_w);
        hs  = 18'(eff_h);
        cxs = (x0_reg < 0) ? 18'sd0 : x0_reg;
        cxe = (x1_reg > ws - 18'sd1) ? ws - 18'sd1 : x1_reg;
        cys = (y0_reg < 0) ? 18'sd0 : y0_reg;
        cye = (y1_reg > hs - 18'sd1) ? hs - 18'sd1 : y1_reg;
        ys_empty = (cxs > cxe) || (cys > cye);
    end

    // Draw size test, row address, and pixel access address and bounds test.
    logic          too_small;
    logic [AW-1:0] row_addr;
    logic [AW-1:0] pix_addr;
    logic          outside;

    always_comb
    begin
        too_small = (x1_reg - x0_reg < $signed({9'd0, r_reg, 1'b0}))
                 || (y1_reg - y0_reg < $signed({9'd0, r_reg, 1'b0}));
        row_addr  = AW'(sy_reg[YW-1:0]) * AW'(eff_w);
        pix_addr  = AW'(y0_reg[YW-1:0]) * AW'(eff_w) + AW'(x0_reg[XW-1:0]);
        outside   = (x0_reg < 0) || (y0_reg < 0)
                 || (x0_reg >= ws) || (y0_reg >= hs);
    end

    // Bit-serial square root trial.
    logic [15:0] trial_sq;
    logic [7:0]  trial;

    always_comb
    begin
        trial    = root_reg | (8'd1 << bit_reg[2:0]);
        trial_sq = trial * trial;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
                if (clr_reg == (AW+1)'(DEPTH - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (in_valid)
                    state_next = S_SETUP;
            S_SETUP:
                if (func_reg == FUNC_DRAW)
                begin
                    if (too_small || ys_empty)
                        state_next = S_RESULT;
                    else
                        state_next = S_SQRT;
                end
                else if ((func_reg == FUNC_READ || func_reg == FUNC_WRITE)
                         && !outside)
                    state_next = S_ACC;
                else
                    state_next = S_RESULT;
            S_SQRT:
                if (!in_corner_row || bit_reg == 4'd0)
                    state_next = S_PIX_RD;
            S_PIX_RD:
                state_next = S_PIX_WAIT;
            S_PIX_WAIT:
                state_next = S_PIX_WR;
            S_PIX_WR:
                if (sx_reg < xe_reg)
                    state_next = S_PIX_RD;
                else if (sy_reg < ye_reg)
                    state_next = S_SQRT;
                else
                    state_next = S_RESULT;
            S_ACC:
                state_next = S_ACC_WAIT;
            S_ACC_WAIT:
                state_next = S_RESULT;
            S_RESULT:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Memory control.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = rd_data | color_reg;
        mem_raddr = addr_reg;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg[AW-1:0];
            mem_wdata = 8'd0;
        end
        else if (state_reg == S_PIX_WR && covered)
        begin
            mem_we = 1'b1;
        end
        else if (state_reg == S_ACC && func_reg == FUNC_WRITE)
        begin
            mem_we    = 1'b1;
            mem_wdata = color_reg;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESULT);
    assign status    = status_reg;
    assign pixel     = pixel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    func_reg   <= func;
                    x0_reg     <= 18'(left);
                    y0_reg     <= 18'(top);
                    x1_reg     <= 18'(right);
                    y1_reg     <= 18'(bottom);
                    r_reg      <= radius;
                    color_reg  <= color;
                    status_reg <= ST_DONE;
                    pixel_reg  <= 8'd0;
                end
            S_SETUP:
            begin
                sx_reg   <= cxs;
                xs_reg   <= cxs;
                xe_reg   <= cxe;
                sy_reg   <= cys;
                ye_reg   <= cye;
                root_reg <= 8'd0;
                bit_reg  <= 4'd7;
                addr_reg <= pix_addr;
                if (func_reg == FUNC_DRAW && too_small)
                    status_reg <= ST_SMALL;
                else if ((func_reg == FUNC_READ || func_reg == FUNC_WRITE)
                         && outside)
                    status_reg <= ST_OUTSIDE;
            end
            S_SQRT:
            begin
                if (trial_sq <= rad_sq)
                    root_reg <= trial;
                bit_reg <= bit_reg - 1'b1;
                if (!in_corner_row || bit_reg == 4'd0)
                begin
                    if (trial_sq <= rad_sq)
                        span_reg <= trial;
                    else
                        span_reg <= root_reg;
                    addr_reg <= row_addr + AW'(sx_reg[XW-1:0]);
                end
            end
            S_PIX_WR:
            begin
                if (sx_reg < xe_reg)
                begin
                    sx_reg   <= sx_reg + 18'sd1;
                    addr_reg <= addr_reg + 1'b1;
                end
                else
                begin
                    sx_reg   <= xs_reg;
                    sy_reg   <= sy_reg + 18'sd1;
                    root_reg <= 8'd0;
                    bit_reg  <= 4'd7;
                end
            end
            S_ACC_WAIT:
                if (func_reg == FUNC_READ)
                    pixel_reg <= rd_data;
            default:
            begin
            end
        endcase
    end

    // The input side is closed while a result is pending or memory clears.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input open while result pending");

    // A pending result holds until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pixel))
        else $error("result changed while stalled");

    // Only read items return a nonzero pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && func_reg != FUNC_READ |-> pixel == 8'd0)
        else $error("pixel nonzero for a non-read item");

endmodule
